// ===== src/assert_macros.svh =====
// Concurrent assertion helpers used by the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/gltok_pkg.sv =====
package gltok_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int SYMBOL_BYTES  = 4;
    localparam int ADDR_W  = $clog2(TABLE_ENTRIES);
    localparam int LEN_W   = 3;
    localparam int BYTES_W = 8 * SYMBOL_BYTES;
    localparam int ID_W    = 8;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W = BYTES_W + LEN_W;
    localparam int CFG_IDX_W = 8;

    localparam logic [ID_W-1:0] END_TOKEN_RESET = 8'd10;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_TEXT = 2'd1;
    localparam logic [1:0] REQ_END  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 8'd1;

    typedef struct packed {
        logic latch;
        logic dec;
        logic ld_read;
        logic ld_write;
        logic scan_start;
        logic scan_step;
        logic match_apply;
        logic end_apply;
        logic fin_push;
    } t_cmd;

    typedef struct packed {
        logic is_load;
        logic is_text;
        logic is_end;
        logic loaded;
        logic need_match;
        logic scan_done;
        logic found;
        logic can_push;
        logic pend_v;
        logic out_free;
    } t_status;

    function automatic logic [BYTES_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [BYTES_W-1:0] m;
        m = '0;
        for (int b = 0; b < SYMBOL_BYTES; b++) begin
            if (LEN_W'(b) < len) m[8*b +: 8] = 8'hFF;
        end
        return m;
    endfunction

endpackage

// ===== src/gltok_ram.sv =====
module gltok_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/gltok_ctrl.sv =====
module gltok_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gltok_pkg::t_status i_status,
    output gltok_pkg::t_cmd   o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DEC   = 8'b0000_0010,
        S_LD_RD = 8'b0000_0100,
        S_LD_WR = 8'b0000_1000,
        S_CHECK = 8'b0001_0000,
        S_SCAN  = 8'b0010_0000,
        S_MATCH = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                if (i_status.is_load) begin
                    n_state = S_LD_RD;
                end else if (i_status.is_text || i_status.is_end) begin
                    o_cmd.dec = 1'b1;
                    n_state   = i_status.loaded ? S_CHECK : S_IDLE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LD_RD: begin
                o_cmd.ld_read = 1'b1;
                n_state       = S_LD_WR;
            end
            S_LD_WR: begin
                o_cmd.ld_write = 1'b1;
                n_state        = S_IDLE;
            end
            S_CHECK: begin
                if (i_status.need_match) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else if (i_status.is_end) begin
                    if (i_status.can_push) begin
                        o_cmd.end_apply = 1'b1;
                        n_state         = S_FIN;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) n_state = S_MATCH;
            end
            S_MATCH: begin
                if (!i_status.found || i_status.can_push) begin
                    o_cmd.match_apply = 1'b1;
                    n_state           = S_CHECK;
                end
            end
            S_FIN: begin
                if (!i_status.pend_v) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.fin_push = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);
endmodule

// ===== src/gltok_dp.sv =====
`include "assert_macros.svh"

module gltok_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gltok_pkg::t_cmd                    i_cmd,
    output gltok_pkg::t_status                 o_status,
    input  logic                               i_cfg_valid,
    input  logic [gltok_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gltok_pkg::ID_W-1:0]         i_cfg_data,
    input  logic [1:0]                         i_req_type,
    input  logic [7:0]                         i_entry_index,
    input  logic [31:0]                        i_entry_bytes,
    input  logic [2:0]                         i_entry_len,
    input  logic [7:0]                         i_text_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [gltok_pkg::ID_W-1:0]         o_token_id,
    output logic                               o_last_token
);
    localparam int AW = gltok_pkg::ADDR_W;
    localparam int LW = gltok_pkg::LEN_W;
    localparam int BW = gltok_pkg::BYTES_W;
    localparam int IW = gltok_pkg::ID_W;
    localparam int CW = gltok_pkg::CNT_W;
    localparam int NE = gltok_pkg::TABLE_ENTRIES;
    localparam int SB = gltok_pkg::SYMBOL_BYTES;
    localparam logic [LW-1:0] SB_L = LW'(SB);
    localparam logic [IW-1:0] END_RST = gltok_pkg::END_TOKEN_RESET;

    logic [1:0]    r_req;
    logic [7:0]    r_idx;
    logic [BW-1:0] r_ebytes;
    logic [LW-1:0] r_elen;
    logic [7:0]    r_text;

    logic [IW-1:0] r_begin_tok, r_end_tok;
    logic [BW-1:0] r_la;
    logic [LW-1:0] r_cnt;
    logic          r_open, r_loaded;
    logic [CW-1:0] r_lc [SB];
    logic          r_vld [NE];

    logic [AW-1:0] r_addr, r_raddr;
    logic          r_iss, r_rv;
    logic [LW-1:0] r_maxlen, r_best_len;
    logic [AW-1:0] r_best_id;

    logic          r_pend_v;
    logic [IW-1:0] r_pend_id;
    logic          r_ov, r_olast;
    logic [IW-1:0] r_oid;

    logic [AW-1:0]                   ram_raddr;
    logic [gltok_pkg::ENTRY_W-1:0]   ram_rdata, ram_wdata;
    logic [LW-1:0] rd_len, len_sat, longest, used;
    logic [BW-1:0] rd_bytes;
    logic          hit, out_free, can_push, produce;
    logic [IW-1:0] prod_id;

    assign ram_raddr = i_cmd.ld_read ? r_idx[AW-1:0] : r_addr;
    assign len_sat   = (r_elen > SB_L) ? SB_L : r_elen;
    assign ram_wdata = {r_ebytes, len_sat};

    gltok_ram #(.WIDTH(gltok_pkg::ENTRY_W), .DEPTH(NE)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_write),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // slot length reads as zero until its first load
    assign rd_len   = r_vld[r_raddr] ? ram_rdata[LW-1:0] : '0;
    assign rd_bytes = ram_rdata[gltok_pkg::ENTRY_W-1:LW];

    always_comb begin
        longest = LW'(1);
        for (int k = 1; k < SB; k++) begin
            if (r_lc[k] != '0) longest = LW'(k + 1);
        end
    end

    assign hit = r_rv && (rd_len != '0) && (rd_len <= r_maxlen) && (rd_len > r_best_len)
                 && (((rd_bytes ^ r_la) & gltok_pkg::byte_mask(rd_len)) == '0);

    assign out_free = !r_ov || !i_out_stall;
    assign can_push = !r_pend_v || out_free;
    assign used     = (r_best_len != '0) ? r_best_len : LW'(1);

    always_comb begin
        produce = 1'b0;
        prod_id = r_end_tok;
        if (i_cmd.dec && !r_open && r_loaded) begin
            produce = 1'b1;
            prod_id = r_begin_tok;
        end else if (i_cmd.match_apply && r_best_len != '0) begin
            produce = 1'b1;
            prod_id = IW'(r_best_id);
        end else if (i_cmd.end_apply) begin
            produce = 1'b1;
            prod_id = r_end_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req    <= i_req_type;
            r_idx    <= i_entry_index;
            r_ebytes <= i_entry_bytes;
            r_elen   <= i_entry_len;
            r_text   <= i_text_byte;
        end
        if (i_cmd.scan_start) begin
            r_addr     <= AW'(NE - 1);
            r_best_len <= '0;
            r_maxlen   <= (r_req == gltok_pkg::REQ_END && r_cnt < longest) ? r_cnt : longest;
        end else if (i_cmd.scan_step && r_iss) begin
            r_addr <= r_addr - AW'(1);
        end
        // read address follows the RAM so the length and data line up
        if (i_cmd.scan_step || i_cmd.ld_read) r_raddr <= ram_raddr;
        if (hit) begin
            r_best_len <= rd_len;
            r_best_id  <= r_raddr;
        end
        if (produce) r_pend_id <= prod_id;
        if (produce && r_pend_v) begin
            r_oid   <= r_pend_id;
            r_olast <= 1'b0;
        end else if (i_cmd.fin_push) begin
            r_oid   <= r_pend_id;
            r_olast <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin_tok <= '0;
            r_end_tok   <= END_RST;
            r_la        <= '0;
            r_cnt       <= '0;
            r_open      <= 1'b0;
            r_loaded    <= 1'b0;
            r_iss       <= 1'b0;
            r_rv        <= 1'b0;
            r_pend_v    <= 1'b0;
            r_ov        <= 1'b0;
            for (int k = 0; k < SB; k++) r_lc[k] <= '0;
            for (int e = 0; e < NE; e++) r_vld[e] <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == gltok_pkg::CFG_BEGIN) r_begin_tok <= i_cfg_data;
            if (i_cfg_valid && i_cfg_index == gltok_pkg::CFG_END)   r_end_tok   <= i_cfg_data;

            if (i_cmd.ld_write) begin
                for (int k = 0; k < SB; k++) begin
                    r_lc[k] <= r_lc[k] - CW'(rd_len == LW'(k + 1)) + CW'(len_sat == LW'(k + 1));
                end
                r_vld[r_idx[AW-1:0]] <= 1'b1;
                if (len_sat != '0) r_loaded <= 1'b1;
            end

            if (i_cmd.dec) begin
                if (!r_loaded) begin
                    r_la   <= '0;
                    r_cnt  <= '0;
                    r_open <= 1'b0;
                end else begin
                    r_open <= (r_req == gltok_pkg::REQ_TEXT);
                    if (r_req == gltok_pkg::REQ_TEXT && r_cnt < SB_L) begin
                        r_la  <= r_la | (BW'(r_text) << {r_cnt, 3'b000});
                        r_cnt <= r_cnt + LW'(1);
                    end
                end
            end else if (i_cmd.match_apply) begin
                r_la  <= r_la >> {used, 3'b000};
                r_cnt <= (used >= r_cnt) ? '0 : r_cnt - used;
            end else if (i_cmd.end_apply) begin
                r_la   <= '0;
                r_cnt  <= '0;
                r_open <= 1'b0;
            end

            if (i_cmd.scan_start) begin
                r_iss <= 1'b1;
                r_rv  <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rv <= r_iss;
                if (r_iss && r_addr == '0) r_iss <= 1'b0;
            end else begin
                r_rv <= 1'b0;
            end

            if (produce) r_pend_v <= 1'b1;
            else if (i_cmd.fin_push) r_pend_v <= 1'b0;

            if ((produce && r_pend_v) || i_cmd.fin_push) r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
        end
    end

    always_comb begin
        o_status            = '0;
        o_status.is_load    = (r_req == gltok_pkg::REQ_LOAD);
        o_status.is_text    = (r_req == gltok_pkg::REQ_TEXT);
        o_status.is_end     = (r_req == gltok_pkg::REQ_END);
        o_status.loaded     = r_loaded;
        o_status.need_match = (r_req == gltok_pkg::REQ_END) ? (r_cnt != '0)
                                                            : (r_cnt >= longest);
        o_status.scan_done  = r_rv && (r_raddr == '0);
        o_status.found      = (r_best_len != '0);
        o_status.can_push   = can_push;
        o_status.pend_v     = r_pend_v;
        o_status.out_free   = out_free;
    end

    assign o_out_valid  = r_ov;
    assign o_token_id   = r_oid;
    assign o_last_token = r_olast;

    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= SB_L, "lookahead count overflow")
    `ASSERT_IMPLIES(a_push_room, i_clk, i_rst_n, produce && r_pend_v, out_free,
                    "result pushed into a busy output register")
    `ASSERT_IMPLIES(a_best_bound, i_clk, i_rst_n, r_rv, r_best_len <= r_maxlen,
                    "match longer than allowed")
endmodule

// ===== src/greedy_longest_match_tokenizer_core.sv =====
// Load item: decode, RAM read and RAM write states, then back to idle for the next input; no result.
// Text/end item: decode, check, then a scan and match state per match attempt, then finish; each attempt
// sweeps the 256-entry symbol RAM, one read per cycle. Up to 4 attempts for text, 3 for end.
// Before any load, and for an unknown request, the item ends at decode with no result. Output stalls hold it up.
// One item at a time; results leave through a one-deep output register.
// Reset (synchronous, active low) clears slot valid bits, length counts and buffer at once.
module greedy_longest_match_tokenizer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_entry_index,
    input  logic [31:0] i_entry_bytes,
    input  logic [2:0]  i_entry_len,
    input  logic [7:0]  i_text_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_token_id,
    output logic        o_last_token,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    gltok_pkg::t_cmd    cmd;
    gltok_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    gltok_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gltok_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_entry_index (i_entry_index),
        .i_entry_bytes (i_entry_bytes),
        .i_entry_len   (i_entry_len),
        .i_text_byte   (i_text_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_token_id    (o_token_id),
        .o_last_token  (o_last_token)
    );
endmodule
